// ===== hw/rtl/hns_pkg.sv =====
package hns_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int SAMPLE_W = 16;
  localparam int ROW_W = 16;
  localparam int BANK_W = 2;
  localparam int ADDR_W = BANK_W + COL_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int COMP_W = 16;
  localparam logic [COMP_W-1:0] UNIT_ONE = 16'd16384;

  typedef enum logic [1:0] {
    REG_ROW_WIDTH   = 2'd0,
    REG_ROW_COUNT   = 2'd1,
    REG_HEIGHT_SCALE = 2'd2,
    REG_CELL_SIZE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] down;
    logic [SAMPLE_W-1:0] up;
  } hns_taps_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } hns_vec_t;

endpackage

// ===== hw/rtl/hns_store.sv =====
module hns_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [hns_pkg::ADDR_W-1:0]  addr,
  input  logic [hns_pkg::SAMPLE_W-1:0] wdata,
  output logic [hns_pkg::SAMPLE_W-1:0] rdata
);
  import hns_pkg::*;

  logic [SAMPLE_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/hns_norm.sv =====
module hns_norm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  hns_pkg::hns_taps_t    taps,
  input  logic [15:0]           scale,
  input  logic [15:0]           spacing,
  output logic                  done,
  output hns_pkg::hns_vec_t     res
);
  import hns_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE, S_LOAD, S_NORM, S_SQ, S_SQRT, S_DINIT, S_DSTEP
  } state_t;

  state_t      state;
  logic [5:0]  cnt;
  logic [1:0]  k;
  logic [31:0] m [3];
  logic        neg [3];
  logic [15:0] dfx, dfz;
  logic [63:0] prod, sum, v, rr, bitv;
  logic [31:0] q;
  logic [47:0] rem, dv;
  logic [14:0] quo;

  logic [31:0] mul_a, mul_b, mx;
  logic [63:0] trial;
  logic        ge;
  logic [14:0] quo_next;
  logic [15:0] val;

  always_comb begin
    mul_a = 32'(dfx);
    mul_b = 32'(scale);
    if (state == S_SCALE && cnt[0]) begin
      mul_a = 32'(dfz);
    end else if (state == S_SQ && k != 2'd3) begin
      mul_a = m[k];
      mul_b = m[k];
    end
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    trial = rr + bitv;
    ge = rem >= dv;
    quo_next = {quo[13:0], ge};
    val = neg[k] ? 16'(-{1'b0, quo_next}) : {1'b0, quo_next};
  end

  always_ff @(posedge clk) begin
    done <= !rst && ((state == S_NORM && mx == '0) ||
                     (state == S_DSTEP && cnt == 6'd14 && k == 2'd2));
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      k <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            neg[0] <= taps.left < taps.right;
            neg[1] <= 1'b0;
            neg[2] <= taps.down < taps.up;
            dfx <= (taps.left >= taps.right) ? taps.left - taps.right : taps.right - taps.left;
            dfz <= (taps.down >= taps.up) ? taps.down - taps.up : taps.up - taps.down;
            cnt <= '0;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          prod <= mul_a * mul_b;
          if (cnt[0]) begin
            m[0] <= prod[31:0];
            state <= S_LOAD;
          end
          cnt <= cnt + 6'd1;
        end
        S_LOAD: begin
          m[2] <= prod[31:0];
          m[1] <= {15'd0, spacing, 1'b0};
          state <= S_NORM;
        end
        S_NORM: begin
          if (mx == '0) begin
            res.x <= '0;
            res.y <= UNIT_ONE;
            res.z <= '0;
            state <= S_IDLE;
          end else if (mx[31]) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if (mx[30]) begin
            k <= '0;
            sum <= '0;
            state <= S_SQ;
          end else if (mx[29:22] == '0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 8;
          end else begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end
        end
        S_SQ: begin
          prod <= mul_a * mul_b;
          if (k != 2'd0) sum <= sum + prod;
          if (k == 2'd3) begin
            v <= sum + prod;
            rr <= '0;
            bitv <= 64'd1 << 62;
            cnt <= '0;
            state <= S_SQRT;
          end
          k <= k + 2'd1;
        end
        S_SQRT: begin
          if (v >= trial) begin
            v <= v - trial;
            rr <= (rr >> 1) + bitv;
          end else begin
            rr <= rr >> 1;
          end
          bitv <= bitv >> 2;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            k <= '0;
            state <= S_DINIT;
          end
        end
        S_DINIT: begin
          q <= rr[31:0];
          rem <= {2'b00, m[k], 14'd0} + 48'(rr[31:0]) + {2'b00, m[k], 14'd0};
          dv <= 48'({rr[31:0], 1'b0}) << 14;
          quo <= '0;
          cnt <= '0;
          state <= S_DSTEP;
        end
        S_DSTEP: begin
          if (ge) rem <= rem - dv;
          dv <= dv >> 1;
          quo <= quo_next;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd14) begin
            case (k)
              2'd0: res.x <= val;
              2'd1: res.y <= val;
              default: res.z <= val;
            endcase
            if (k == 2'd2) begin
              state <= S_IDLE;
            end else begin
              k <= k + 2'd1;
              rr <= {32'd0, q};
              state <= S_DINIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/heightmap_normal_stream.sv =====
// each request's normals (up to three) are computed one after another in the shared
// normal unit; a stalled output holds the next normal back until the output is free
// throughput: one request at a time, none taken until all its normals are in the output register
// rst (synchronous) clears counters and restores register defaults;
// line store contents are undefined until written
module heightmap_normal_stream (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [hns_pkg::SAMPLE_W-1:0]  height_sample,
  output logic                          normal_valid,
  input  logic                          normal_stall,
  output logic signed [15:0]            normal_x,
  output logic signed [15:0]            normal_y,
  output logic signed [15:0]            normal_z,
  output logic [hns_pkg::COL_W-1:0]     column,
  output logic [hns_pkg::ROW_W-1:0]     row,
  output logic                          frame_end
);
  import hns_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_PLAN, S_READ, S_CALC, S_OUT, S_FINISH
  } state_t;

  state_t            state;
  logic [10:0]       row_width;
  logic [15:0]       row_count;
  logic [15:0]       height_scale;
  logic [15:0]       cell_size;
  logic [COL_W-1:0]  col_cnt, c, wm1, jcol;
  logic [ROW_W-1:0]  row_cnt, r, jrow;
  logic              last_row, last_col, jfe;
  logic [SAMPLE_W-1:0] sample;
  logic [BANK_W-1:0] p, b_own, b_down, b_up;
  logic [2:0]        pending;
  logic [2:0]        rk;
  hns_taps_t         taps;
  logic              norm_start, norm_done;
  hns_vec_t          norm_res;

  logic [10:0]       w_eff;
  logic [COL_W-1:0]  wm1_in, c_in, cl, cr;
  logic [ROW_W-1:0]  rm1_in, r_in;
  logic [BANK_W-1:0] b_cur, b_mid, b_old;
  logic              we;
  logic              out_free;
  logic [ADDR_W-1:0] addr;
  logic [SAMPLE_W-1:0] rdata;

  assign cfg_ready = 1'b1;
  assign sample_stall = state != S_IDLE;

  always_comb begin
    w_eff = row_width;
    if (row_width == '0) w_eff = 11'd1;
    else if (row_width > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
    wm1_in = COL_W'(w_eff - 11'd1);
    c_in = (col_cnt > wm1_in) ? wm1_in : col_cnt;
    rm1_in = (row_count == '0) ? '0 : row_count - 16'd1;
    r_in = (row_cnt > rm1_in) ? rm1_in : row_cnt;
    b_cur = p;
    b_mid = (p == 2'd0) ? 2'd2 : p - 2'd1;
    b_old = (p == 2'd0) ? 2'd1 : ((p == 2'd1) ? 2'd2 : 2'd0);
    cl = (jcol == '0) ? '0 : jcol - 1'b1;
    cr = (jcol < wm1) ? jcol + 1'b1 : wm1;
    we = state == S_WRITE;
    out_free = !normal_valid || !normal_stall;
    case (rk)
      3'd0: addr = {b_own, cl};
      3'd1: addr = {b_own, cr};
      3'd2: addr = {b_down, jcol};
      default: addr = {b_up, jcol};
    endcase
    if (state == S_WRITE) addr = {b_cur, c};
  end

  hns_store u_store (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (sample),
    .rdata (rdata)
  );

  hns_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .start   (norm_start),
    .taps    (taps),
    .scale   (height_scale),
    .spacing (cell_size),
    .done    (norm_done),
    .res     (norm_res)
  );

  always_ff @(posedge clk) begin
    norm_start <= !rst && state == S_READ && rk == 3'd4;
    if (rst) begin
      state <= S_IDLE;
      row_width <= 11'd1024;
      row_count <= 16'd1024;
      height_scale <= 16'd256;
      cell_size <= 16'd256;
      col_cnt <= '0;
      row_cnt <= '0;
      p <= '0;
      pending <= '0;
      rk <= '0;
      normal_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_ROW_WIDTH: row_width <= cfg_data[10:0];
          REG_ROW_COUNT: row_count <= cfg_data;
          REG_HEIGHT_SCALE: height_scale <= cfg_data;
          REG_CELL_SIZE: cell_size <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_OUT && out_free) begin
        normal_valid <= 1'b1;
      end else if (normal_valid && !normal_stall) begin
        normal_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            sample <= height_sample;
            wm1 <= wm1_in;
            c <= c_in;
            r <= r_in;
            last_row <= r_in == rm1_in;
            last_col <= c_in == wm1_in;
            pending[0] <= r_in != '0;
            pending[1] <= (r_in == rm1_in) && (c_in != '0);
            pending[2] <= (r_in == rm1_in) && (c_in == wm1_in);
            state <= S_WRITE;
          end
        end
        S_WRITE: state <= S_PLAN;
        S_PLAN: begin
          rk <= '0;
          state <= S_READ;
          if (pending[0]) begin
            pending[0] <= 1'b0;
            b_own <= b_mid;
            b_down <= (r == 16'd1) ? b_mid : b_old;
            b_up <= b_cur;
            jcol <= c;
            jrow <= r - 16'd1;
            jfe <= 1'b0;
          end else if (pending[1] || pending[2]) begin
            pending[1] <= 1'b0;
            if (!pending[1]) pending[2] <= 1'b0;
            b_own <= b_cur;
            b_down <= (r != '0) ? b_mid : b_cur;
            b_up <= b_cur;
            jcol <= pending[1] ? c - 1'b1 : c;
            jrow <= r;
            jfe <= !pending[1];
          end else begin
            state <= S_FINISH;
          end
        end
        S_READ: begin
          case (rk)
            3'd1: taps.left <= rdata;
            3'd2: taps.right <= rdata;
            3'd3: taps.down <= rdata;
            3'd4: taps.up <= rdata;
            default: ;
          endcase
          rk <= rk + 3'd1;
          if (rk == 3'd4) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (norm_done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            normal_x <= norm_res.x;
            normal_y <= norm_res.y;
            normal_z <= norm_res.z;
            column <= jcol;
            row <= jrow;
            frame_end <= jfe;
            state <= S_PLAN;
          end
        end
        S_FINISH: begin
          if (last_col) begin
            col_cnt <= '0;
            row_cnt <= last_row ? '0 : r + 16'd1;
            p <= (p == 2'd2) ? 2'd0 : p + 2'd1;
          end else begin
            col_cnt <= c + 1'b1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/heightmap_normal_stream_tb.sv =====
`timescale 1ns / 1ps

module heightmap_normal_stream_tb;
  import hns_pkg::*;

  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] rw;
    logic fe;
  } normal_rec_t;

  class normal_scoreboard;
    logic [SAMPLE_W-1:0] st_old[MAX_WIDTH];
    logic [SAMPLE_W-1:0] st_mid[MAX_WIDTH];
    logic [SAMPLE_W-1:0] st_cur[MAX_WIDTH];
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned cfg_width;
    int unsigned cfg_rows;
    longint unsigned cfg_scale;
    longint unsigned cfg_cell;
    normal_rec_t pending_normals[$];
    int errors;

    function new();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        st_old[i] = '0;
        st_mid[i] = '0;
        st_cur[i] = '0;
      end
      col_cnt = 0;
      row_cnt = 0;
      cfg_width = 1024;
      cfg_rows = 1024;
      cfg_scale = 256;
      cfg_cell = 256;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] val);
      case (idx)
        REG_ROW_WIDTH: cfg_width = 32'(val[10:0]);
        REG_ROW_COUNT: cfg_rows = 32'(val);
        REG_HEIGHT_SCALE: cfg_scale = 64'(val);
        default: cfg_cell = 64'(val);
      endcase
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void push_normal(logic [15:0] hl, logic [15:0] hr, logic [15:0] hd,
                              logic [15:0] hu, int unsigned c, int unsigned r, bit fe);
      longint unsigned m[3];
      bit neg[3];
      longint unsigned mx;
      longint unsigned q;
      longint unsigned val;
      normal_rec_t rec;
      logic [15:0] o[3];
      neg[0] = hl < hr;
      m[0] = (neg[0] ? longint'(hr - hl) : longint'(hl - hr)) * cfg_scale;
      m[1] = cfg_cell * 2;
      neg[1] = 0;
      neg[2] = hd < hu;
      m[2] = (neg[2] ? longint'(hu - hd) : longint'(hd - hu)) * cfg_scale;
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      if (mx == 0) begin
        o[0] = 0;
        o[1] = UNIT_ONE;
        o[2] = 0;
      end else begin
        while (mx >= (64'd1 << 31)) begin
          for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
          mx = mx >> 1;
        end
        while (mx < (64'd1 << 30)) begin
          for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
          mx = mx << 1;
        end
        q = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
          val = (m[i] * 32768 + q) / (2 * q);
          o[i] = neg[i] ? 16'(-val) : 16'(val);
        end
      end
      rec.x = o[0];
      rec.y = o[1];
      rec.z = o[2];
      rec.col = c[COL_W-1:0];
      rec.rw = r[ROW_W-1:0];
      rec.fe = fe;
      pending_normals.push_back(rec);
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] h);
      int unsigned w;
      int unsigned rows;
      int unsigned c;
      int unsigned r;
      int unsigned cl;
      int unsigned cr;
      bit last_row;
      bit last_col;
      logic [15:0] dn;
      w = cfg_width;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      rows = cfg_rows;
      if (rows < 1) rows = 1;
      c = col_cnt;
      if (c > w - 1) c = w - 1;
      r = row_cnt;
      if (r > rows - 1) r = rows - 1;
      last_row = (r == rows - 1);
      last_col = (c == w - 1);
      st_cur[c] = h;
      cl = (c > 0) ? c - 1 : 0;
      cr = (c + 1 < w) ? c + 1 : w - 1;
      if (r >= 1) begin
        dn = (r == 1) ? st_mid[c] : st_old[c];
        push_normal(st_mid[cl], st_mid[cr], dn, st_cur[c], c, r - 1, 0);
      end
      if (last_row) begin
        if (c >= 1) begin
          cl = (c > 1) ? c - 2 : 0;
          dn = (r >= 1) ? st_mid[c-1] : st_cur[c-1];
          push_normal(st_cur[cl], st_cur[c], dn, st_cur[c-1], c - 1, r, 0);
        end
        if (last_col) begin
          cl = (c > 0) ? c - 1 : 0;
          dn = (r >= 1) ? st_mid[c] : st_cur[c];
          push_normal(st_cur[cl], st_cur[c], dn, st_cur[c], c, r, 1);
        end
      end
      if (last_col) begin
        st_old = st_mid;
        st_mid = st_cur;
        col_cnt = 0;
        row_cnt = last_row ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void check_normal(normal_rec_t got);
      normal_rec_t exp_n;
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected normal x=%0d y=%0d z=%0d col=%0d row=%0d", $time,
                 got.x, got.y, got.z, got.col, got.rw);
        errors++;
        return;
      end
      exp_n = pending_normals.pop_front();
      if (got.x !== exp_n.x) begin
        $display("%0t: normal_x expected %0d actual %0d", $time, exp_n.x, got.x);
        errors++;
      end
      if (got.y !== exp_n.y) begin
        $display("%0t: normal_y expected %0d actual %0d", $time, exp_n.y, got.y);
        errors++;
      end
      if (got.z !== exp_n.z) begin
        $display("%0t: normal_z expected %0d actual %0d", $time, exp_n.z, got.z);
        errors++;
      end
      if (got.col !== exp_n.col) begin
        $display("%0t: column expected %0d actual %0d", $time, exp_n.col, got.col);
        errors++;
      end
      if (got.rw !== exp_n.rw) begin
        $display("%0t: row expected %0d actual %0d", $time, exp_n.rw, got.rw);
        errors++;
      end
      if (got.fe !== exp_n.fe) begin
        $display("%0t: frame_end expected %0d actual %0d", $time, exp_n.fe, got.fe);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_ROW_WIDTH;
  logic [15:0] cfg_data = '0;
  logic sample_valid = 0;
  logic sample_stall;
  logic [SAMPLE_W-1:0] height_sample = '0;
  logic normal_valid;
  logic normal_stall = 0;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;
  logic frame_end;

  normal_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  heightmap_normal_stream DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .height_sample(height_sample),
    .normal_valid(normal_valid),
    .normal_stall(normal_stall),
    .normal_x(normal_x),
    .normal_y(normal_y),
    .normal_z(normal_z),
    .column(column),
    .row(row),
    .frame_end(frame_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    normal_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    normal_rec_t got;
    if (!rst && normal_valid && !normal_stall) begin
      got.x = normal_x;
      got.y = normal_y;
      got.z = normal_z;
      got.col = column;
      got.rw = row;
      got.fe = frame_end;
      sb.check_normal(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (normal_valid && !normal_stall) || (sample_valid && !sample_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(logic [SAMPLE_W-1:0] h);
    while ($urandom_range(99) < idle_pct) begin
      sample_valid <= 0;
      @(negedge clk);
    end
    sample_valid <= 1;
    height_sample <= h;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(h);
    @(negedge clk);
  endtask

  task automatic drain();
    sample_valid <= 0;
    while (sb.pending_normals.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic set_frame(logic [15:0] w, logic [15:0] rows, logic [15:0] hs,
                           logic [15:0] cs);
    drain();
    write_reg(REG_ROW_WIDTH, w);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_HEIGHT_SCALE, hs);
    write_reg(REG_CELL_SIZE, cs);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: send_sample($urandom_range(1) ? 16'hFFFF : 16'h0000);
        1: send_sample(16'(16'h8000 + $urandom_range(255)));
        default: send_sample(16'($urandom_range(16'hFFFF)));
      endcase
    end
  endtask

  function automatic logic [15:0] pick_wide(int lo);
    case ($urandom_range(3))
      0: return 16'hFFFF;
      1: return 16'(lo);
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  initial begin
    int sent;
    int w;
    int rows;
    int frames;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // extremes in a small frame
    set_frame(3, 2, 256, 256);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    // flat map with zero cell size
    set_frame(2, 2, 0, 0);
    send_random(4);
    // width and row count below range
    set_frame(0, 0, 65535, 65535);
    send_random(2);
    // row counter past a lowered row count
    set_frame(2, 65535, 256, 1);
    send_random(4);
    set_frame(2, 2, 256, 1);
    send_random(2);
    // column counter past a lowered width
    set_frame(4, 2, 1000, 300);
    send_random(3);
    drain();
    write_reg(REG_ROW_WIDTH, 2);
    send_random(3);

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 79; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 79; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      sent = 0;
      while (sent < 42) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 8);
        rows = $urandom_range(1, 5);
        set_frame(16'(w), 16'(rows), pick_wide(0), pick_wide(1));
        if (w < 1) w = 1;
        frames = $urandom_range(1, 2);
        for (int f = 0; f < frames; f++) begin
          if (mode == 0 && sent == 0 && f == 0) begin
            send_random(w);
            drain();
            send_random(w * rows - w);
          end else begin
            send_random(w * rows);
          end
          sent += w * rows;
        end
      end
    end

    // widest row as a single-row frame
    idle_pct = 0;
    stall_pct = 0;
    set_frame(2047, 1, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(1, 16'hFFFF)));
    send_random(32);

    drain();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hns_pkg.sv
hw/rtl/hns_store.sv
hw/rtl/hns_norm.sv
hw/rtl/heightmap_normal_stream.sv
sim/heightmap_normal_stream_tb.sv
